// ===== rtl/sm83of_pkg.sv =====
// ============================================================================
// sm83of_pkg
// Shared types and constants for the operand fetch stage: addressing mode
// codes, result kinds and the request/response beat layouts.
// ============================================================================
package sm83of_pkg;

   localparam logic [15:0] HIGH_PAGE = 16'hFF00;
   localparam int unsigned BYTE_BITS = 8;

   typedef enum logic [4:0] {
      MODE_IMP    = 5'd0,
      MODE_R_D16  = 5'd1,
      MODE_R_R    = 5'd2,
      MODE_MR_R   = 5'd3,
      MODE_R      = 5'd4,
      MODE_R_D8   = 5'd5,
      MODE_R_MR   = 5'd6,
      MODE_R_HLI  = 5'd7,
      MODE_R_HLD  = 5'd8,
      MODE_HLI_R  = 5'd9,
      MODE_HLD_R  = 5'd10,
      MODE_R_A8   = 5'd11,
      MODE_A8_R   = 5'd12,
      MODE_HL_SPR = 5'd13,
      MODE_D16    = 5'd14,
      MODE_D8     = 5'd15,
      MODE_D16_R  = 5'd16,
      MODE_MR_D8  = 5'd17,
      MODE_MR     = 5'd18,
      MODE_A16_R  = 5'd19,
      MODE_R_A16  = 5'd20
   } mode_type;

   typedef enum logic [1:0] {
      KIND_REQUEST = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic        req_type;
      logic        has_instruction;
      logic [4:0]  mode;
      logic [15:0] first_reg_value;
      logic        first_reg_is_c;
      logic [15:0] second_reg_value;
      logic        second_reg_is_c;
      logic [15:0] pc_in;
      logic [15:0] hl_in;
      logic [7:0]  bus_data;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] read_address;
      logic [15:0] fetched_value;
      logic [15:0] dest_address;
      logic        dest_in_memory;
      logic [15:0] pc_out;
      logic        hl_write;
      logic [15:0] hl_out;
      logic [1:0]  bus_reads;
   } rsp_payload_type;

endpackage

// ===== rtl/sm83of_req_if.sv =====
// ============================================================================
// sm83of_req_if
// Request channel: start and bus data beats with valid/ready handshake.
// ============================================================================
interface sm83of_req_if;
   import sm83of_pkg::*;

   logic        valid;
   logic        ready;
   logic        req_type;
   logic        has_instruction;
   logic [4:0]  mode;
   logic [15:0] first_reg_value;
   logic        first_reg_is_c;
   logic [15:0] second_reg_value;
   logic        second_reg_is_c;
   logic [15:0] pc_in;
   logic [15:0] hl_in;
   logic [7:0]  bus_data;

   modport source (
      output valid, req_type, has_instruction, mode, first_reg_value, first_reg_is_c,
             second_reg_value, second_reg_is_c, pc_in, hl_in, bus_data,
      input  ready
   );

   modport sink (
      input  valid, req_type, has_instruction, mode, first_reg_value, first_reg_is_c,
             second_reg_value, second_reg_is_c, pc_in, hl_in, bus_data,
      output ready
   );

endinterface

// ===== rtl/sm83of_rsp_if.sv =====
// ============================================================================
// sm83of_rsp_if
// Response channel: read request, done and error beats with valid/ready.
// ============================================================================
interface sm83of_rsp_if;
   import sm83of_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] read_address;
   logic [15:0] fetched_value;
   logic [15:0] dest_address;
   logic        dest_in_memory;
   logic [15:0] pc_out;
   logic        hl_write;
   logic [15:0] hl_out;
   logic [1:0]  bus_reads;

   modport source (
      output valid, result_kind, read_address, fetched_value, dest_address,
             dest_in_memory, pc_out, hl_write, hl_out, bus_reads,
      input  ready
   );

   modport sink (
      input  valid, result_kind, read_address, fetched_value, dest_address,
             dest_in_memory, pc_out, hl_write, hl_out, bus_reads,
      output ready
   );

endinterface

// ===== rtl/sm83of_step.sv =====
// ============================================================================
// sm83of_step
// Fetch sequencing state and single-pass result logic for one request beat.
// ============================================================================
module sm83of_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  sm83of_pkg::req_payload_type req,
   output sm83of_pkg::rsp_payload_type rsp
);
   import sm83of_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic [4:0]  held_mode_ff, held_mode_in;
   logic [15:0] held_first_ff, held_first_in;
   logic [15:0] held_second_ff, held_second_in;
   logic [15:0] held_pc_ff, held_pc_in;
   logic [15:0] held_hl_ff, held_hl_in;
   logic [7:0]  low_byte_ff, low_byte_in;

   always_comb begin
      logic [15:0] word;
      logic [15:0] data16;
      logic [15:0] r1_page;
      logic [15:0] r2_page;

      word    = {req.bus_data, low_byte_ff};
      data16  = {{(16 - BYTE_BITS){1'b0}}, req.bus_data};
      r1_page = req.first_reg_is_c ? (req.first_reg_value | HIGH_PAGE) : req.first_reg_value;
      r2_page = req.second_reg_is_c ? (req.second_reg_value | HIGH_PAGE)
                                    : req.second_reg_value;

      busy_in        = busy_ff;
      step_in        = step_ff;
      held_mode_in   = held_mode_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      held_pc_in     = held_pc_ff;
      held_hl_in     = held_hl_ff;
      low_byte_in    = low_byte_ff;
      rsp            = '0;

      if (req.req_type == REQ_START) begin
         busy_in = 1'b0;
         step_in = 2'd0;
         rsp.result_kind = KIND_DONE;
         rsp.pc_out      = req.pc_in;
         rsp.hl_out      = req.hl_in;
         if (req.has_instruction) begin
            held_mode_in   = req.mode;
            held_first_in  = req.first_reg_value;
            held_second_in = req.second_reg_value;
            held_pc_in     = req.pc_in;
            held_hl_in     = req.hl_in;
            low_byte_in    = '0;
            case (req.mode) inside
               MODE_IMP: begin
               end
               MODE_R: begin
                  rsp.fetched_value = req.first_reg_value;
               end
               MODE_R_R: begin
                  rsp.fetched_value = req.second_reg_value;
               end
               MODE_MR_R: begin
                  rsp.fetched_value  = req.second_reg_value;
                  rsp.dest_address   = r1_page;
                  rsp.dest_in_memory = 1'b1;
               end
               MODE_HLI_R, MODE_HLD_R: begin
                  rsp.fetched_value  = req.second_reg_value;
                  rsp.dest_address   = req.first_reg_value;
                  rsp.dest_in_memory = 1'b1;
                  rsp.hl_write       = 1'b1;
                  rsp.hl_out         = (req.mode == MODE_HLI_R) ? req.hl_in + 16'd1
                                                                : req.hl_in - 16'd1;
               end
               MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8, MODE_A8_R, MODE_MR_D8,
               MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
                  busy_in          = 1'b1;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = req.pc_in;
               end
               MODE_R_MR: begin
                  busy_in          = 1'b1;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = r2_page;
               end
               MODE_R_HLI, MODE_R_HLD: begin
                  busy_in          = 1'b1;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = req.second_reg_value;
               end
               MODE_MR: begin
                  busy_in          = 1'b1;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = req.first_reg_value;
               end
               default: begin
                  rsp.result_kind = KIND_ERROR;
               end
            endcase
         end
      end else if (!busy_ff) begin
         rsp.result_kind = KIND_ERROR;
      end else begin
         busy_in         = 1'b0;
         rsp.result_kind = KIND_DONE;
         rsp.pc_out      = held_pc_ff;
         rsp.hl_out      = held_hl_ff;
         rsp.bus_reads   = 2'd1;
         rsp.fetched_value = data16;
         case (held_mode_ff) inside
            MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8: begin
               rsp.pc_out = held_pc_ff + 16'd1;
            end
            MODE_A8_R: begin
               rsp.pc_out         = held_pc_ff + 16'd1;
               rsp.fetched_value  = held_second_ff;
               rsp.dest_address   = data16 | HIGH_PAGE;
               rsp.dest_in_memory = 1'b1;
            end
            MODE_MR_D8: begin
               rsp.pc_out         = held_pc_ff + 16'd1;
               rsp.dest_address   = held_first_ff;
               rsp.dest_in_memory = 1'b1;
            end
            MODE_R_MR: begin
            end
            MODE_R_HLI, MODE_R_HLD: begin
               rsp.hl_write = 1'b1;
               rsp.hl_out   = (held_mode_ff == MODE_R_HLI) ? held_hl_ff + 16'd1
                                                           : held_hl_ff - 16'd1;
            end
            MODE_MR: begin
               rsp.dest_address   = held_first_ff;
               rsp.dest_in_memory = 1'b1;
            end
            MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
               if (step_ff == 2'd0) begin
                  busy_in          = 1'b1;
                  step_in          = 2'd1;
                  low_byte_in      = req.bus_data;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = held_pc_ff + 16'd1;
               end else if (held_mode_ff == MODE_R_A16 && step_ff == 2'd1) begin
                  busy_in          = 1'b1;
                  step_in          = 2'd2;
                  rsp              = '0;
                  rsp.result_kind  = KIND_REQUEST;
                  rsp.read_address = word;
               end else if (held_mode_ff == MODE_R_A16) begin
                  rsp.pc_out    = held_pc_ff + 16'd2;
                  rsp.bus_reads = 2'd3;
               end else begin
                  rsp.pc_out    = held_pc_ff + 16'd2;
                  rsp.bus_reads = 2'd2;
                  if (held_mode_ff == MODE_A16_R || held_mode_ff == MODE_D16_R) begin
                     rsp.fetched_value  = held_second_ff;
                     rsp.dest_address   = word;
                     rsp.dest_in_memory = 1'b1;
                  end else begin
                     rsp.fetched_value = word;
                  end
               end
            end
            default: begin
               rsp = '0;
               rsp.result_kind = KIND_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         step_ff        <= '0;
         held_mode_ff   <= '0;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         held_pc_ff     <= '0;
         held_hl_ff     <= '0;
         low_byte_ff    <= '0;
      end else if (accept) begin
         busy_ff        <= busy_in;
         step_ff        <= step_in;
         held_mode_ff   <= held_mode_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         held_pc_ff     <= held_pc_in;
         held_hl_ff     <= held_hl_in;
         low_byte_ff    <= low_byte_in;
      end
   end

   // sequencing consistency
   assert property (@(posedge clock) disable iff (reset) step_ff != 2'd3)
      else $error("step beyond third read");

   assert property (@(posedge clock) disable iff (reset)
      (step_ff == 2'd2) |-> (held_mode_ff == MODE_R_A16))
      else $error("third read outside indirect 16-bit mode");

   assert property (@(posedge clock) disable iff (reset)
      (step_ff == 2'd1) |-> (held_mode_ff == MODE_R_D16 || held_mode_ff == MODE_D16 ||
                             held_mode_ff == MODE_A16_R || held_mode_ff == MODE_D16_R ||
                             held_mode_ff == MODE_R_A16))
      else $error("second read outside 16-bit mode");

endmodule

// ===== rtl/sm83_operand_fetch.sv =====
// ============================================================================
// sm83_operand_fetch
// Operand fetch stage: sequences immediate and indirect bus reads and
// reports read requests, done results and mode errors.
// response: computed combinationally, registered in the response or skid entry
// throughput: one request beat per cycle while the skid entry is empty, set by the single-pass step logic
// output side: response register plus one skid entry, so a stalled response
// does not stop the next request beat from being accepted
// reset: synchronous, clears the fetch state and empties both output entries
// ============================================================================
module sm83_operand_fetch (
   input  logic         clock,
   input  logic         reset,
   sm83of_req_if.sink   req_ch,
   sm83of_rsp_if.source rsp_ch
);
   import sm83of_pkg::*;

   req_payload_type req_payload;
   rsp_payload_type step_result;
   rsp_payload_type main_data_ff, main_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            accept;
   logic            pop;

   assign req_payload = '{
      req_type:         req_ch.req_type,
      has_instruction:  req_ch.has_instruction,
      mode:             req_ch.mode,
      first_reg_value:  req_ch.first_reg_value,
      first_reg_is_c:   req_ch.first_reg_is_c,
      second_reg_value: req_ch.second_reg_value,
      second_reg_is_c:  req_ch.second_reg_is_c,
      pc_in:            req_ch.pc_in,
      hl_in:            req_ch.hl_in,
      bus_data:         req_ch.bus_data
   };

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && !skid_valid_ff;
   assign pop          = main_valid_ff && rsp_ch.ready;

   sm83of_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .rsp    (step_result)
   );

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept;
            main_data_in  = step_result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid          = main_valid_ff;
   assign rsp_ch.result_kind    = main_data_ff.result_kind;
   assign rsp_ch.read_address   = main_data_ff.read_address;
   assign rsp_ch.fetched_value  = main_data_ff.fetched_value;
   assign rsp_ch.dest_address   = main_data_ff.dest_address;
   assign rsp_ch.dest_in_memory = main_data_ff.dest_in_memory;
   assign rsp_ch.pc_out         = main_data_ff.pc_out;
   assign rsp_ch.hl_write       = main_data_ff.hl_write;
   assign rsp_ch.hl_out         = main_data_ff.hl_out;
   assign rsp_ch.bus_reads      = main_data_ff.bus_reads;

   // skid entry only fills behind a held response
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without main entry");

   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !rsp_ch.ready && !skid_valid_ff && accept) |=> skid_valid_ff)
      else $error("beat accepted behind held response was dropped");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ch.ready) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to main entry");

endmodule

// ===== sim/sm83of_fetch_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sm83of_fetch_checker
// Watches the request and response channels of the operand fetch stage. It
// keeps its own copy of the fetch state, works out the response for every
// accepted request beat and compares each accepted response beat, field by
// field, with the oldest one still pending.
// ============================================================================
module sm83of_fetch_checker
   import sm83of_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   sm83of_req_if req_mon,
   sm83of_rsp_if rsp_mon,
   output int    fail_count,
   output int    outstanding,
   output int    rsp_count,
   output int    read_count,
   output int    done_count,
   output int    fault_count
);

   logic        fetching;
   logic [1:0]  step;
   mode_type    hold_mode;
   logic [15:0] hold_first;
   logic [15:0] hold_second;
   logic [15:0] hold_pc;
   logic [15:0] hold_hl;
   logic [7:0]  low_byte;

   rsp_payload_type pending_results[$];

   function automatic rsp_payload_type request_beat(logic [15:0] addr);
      rsp_payload_type r;
      r = '0;
      r.result_kind = KIND_REQUEST;
      r.read_address = addr;
      return r;
   endfunction

   function automatic rsp_payload_type fetch_result(req_payload_type b);
      rsp_payload_type r;
      logic [15:0]     word;
      r = '0;
      if (b.req_type == REQ_START) begin
         fetching = 1'b0;
         step = 2'd0;
         r.result_kind = KIND_DONE;
         r.pc_out = b.pc_in;
         r.hl_out = b.hl_in;
         if (b.has_instruction) begin
            hold_mode = mode_type'(b.mode);
            hold_first = b.first_reg_value;
            hold_second = b.second_reg_value;
            hold_pc = b.pc_in;
            hold_hl = b.hl_in;
            low_byte = 8'h00;
            case (hold_mode)
               MODE_IMP: ;
               MODE_R: r.fetched_value = b.first_reg_value;
               MODE_R_R: r.fetched_value = b.second_reg_value;
               MODE_MR_R: begin
                  r.fetched_value = b.second_reg_value;
                  r.dest_address = b.first_reg_is_c ? (b.first_reg_value | HIGH_PAGE)
                                                    : b.first_reg_value;
                  r.dest_in_memory = 1'b1;
               end
               MODE_HLI_R, MODE_HLD_R: begin
                  r.fetched_value = b.second_reg_value;
                  r.dest_address = b.first_reg_value;
                  r.dest_in_memory = 1'b1;
                  r.hl_write = 1'b1;
                  r.hl_out = (hold_mode == MODE_HLI_R) ? b.hl_in + 16'd1 : b.hl_in - 16'd1;
               end
               MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8, MODE_A8_R, MODE_MR_D8,
               MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
                  fetching = 1'b1;
                  r = request_beat(b.pc_in);
               end
               MODE_R_MR: begin
                  fetching = 1'b1;
                  r = request_beat(b.second_reg_is_c ? (b.second_reg_value | HIGH_PAGE)
                                                     : b.second_reg_value);
               end
               MODE_R_HLI, MODE_R_HLD: begin
                  fetching = 1'b1;
                  r = request_beat(b.second_reg_value);
               end
               MODE_MR: begin
                  fetching = 1'b1;
                  r = request_beat(b.first_reg_value);
               end
               default: r.result_kind = KIND_ERROR;
            endcase
         end
      end else if (!fetching) begin
         r.result_kind = KIND_ERROR;
      end else begin
         word = {b.bus_data, low_byte};
         fetching = 1'b0;
         r.result_kind = KIND_DONE;
         r.fetched_value = {8'h00, b.bus_data};
         r.pc_out = hold_pc;
         r.hl_out = hold_hl;
         r.bus_reads = 2'd1;
         case (hold_mode)
            MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8: r.pc_out = hold_pc + 16'd1;
            MODE_A8_R: begin
               r.fetched_value = hold_second;
               r.dest_address = HIGH_PAGE | {8'h00, b.bus_data};
               r.dest_in_memory = 1'b1;
               r.pc_out = hold_pc + 16'd1;
            end
            MODE_MR_D8: begin
               r.dest_address = hold_first;
               r.dest_in_memory = 1'b1;
               r.pc_out = hold_pc + 16'd1;
            end
            MODE_R_MR: ;
            MODE_R_HLI, MODE_R_HLD: begin
               r.hl_write = 1'b1;
               r.hl_out = (hold_mode == MODE_R_HLI) ? hold_hl + 16'd1 : hold_hl - 16'd1;
            end
            MODE_MR: begin
               r.dest_address = hold_first;
               r.dest_in_memory = 1'b1;
            end
            MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
               if (step == 2'd0) begin
                  low_byte = b.bus_data;
                  step = 2'd1;
                  fetching = 1'b1;
                  r = request_beat(hold_pc + 16'd1);
               end else if (hold_mode == MODE_R_A16 && step == 2'd1) begin
                  step = 2'd2;
                  fetching = 1'b1;
                  r = request_beat(word);
               end else if (hold_mode == MODE_R_A16) begin
                  r.pc_out = hold_pc + 16'd2;
                  r.bus_reads = 2'd3;
               end else begin
                  r.pc_out = hold_pc + 16'd2;
                  r.bus_reads = 2'd2;
                  if (hold_mode == MODE_A16_R || hold_mode == MODE_D16_R) begin
                     r.fetched_value = hold_second;
                     r.dest_address = word;
                     r.dest_in_memory = 1'b1;
                  end else begin
                     r.fetched_value = word;
                  end
               end
            end
            default: begin
               r = '0;
               r.result_kind = KIND_ERROR;
            end
         endcase
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: response %0d %s expected %h actual %h",
                  $time, rsp_count, name, want, got);
      end
   endtask

   // sampled at the falling edge: these are the values the next rising edge sees
   always @(negedge clock) begin : watch
      req_payload_type beat;
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         fetching = 1'b0;
         step = 2'd0;
         hold_mode = MODE_IMP;
         hold_first = '0;
         hold_second = '0;
         hold_pc = '0;
         hold_hl = '0;
         low_byte = '0;
         pending_results.delete();
         fail_count = 0;
         rsp_count = 0;
         read_count = 0;
         done_count = 0;
         fault_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.result_kind, rsp_mon.read_address, rsp_mon.fetched_value,
                   rsp_mon.dest_address, rsp_mon.dest_in_memory, rsp_mon.pc_out,
                   rsp_mon.hl_write, rsp_mon.hl_out, rsp_mon.bus_reads};
            rsp_count++;
            case (got.result_kind)
               KIND_REQUEST: read_count++;
               KIND_DONE: done_count++;
               default: fault_count++;
            endcase
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t ns: response %0d expected none actual kind %0d",
                        $time, rsp_count, got.result_kind);
            end else begin
               want = pending_results.pop_front();
               check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
               check_field("read_address", want.read_address, got.read_address);
               check_field("fetched_value", want.fetched_value, got.fetched_value);
               check_field("dest_address", want.dest_address, got.dest_address);
               check_field("dest_in_memory", 16'(want.dest_in_memory),
                           16'(got.dest_in_memory));
               check_field("pc_out", want.pc_out, got.pc_out);
               check_field("hl_write", 16'(want.hl_write), 16'(got.hl_write));
               check_field("hl_out", want.hl_out, got.hl_out);
               check_field("bus_reads", 16'(want.bus_reads), 16'(got.bus_reads));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            beat = {req_mon.req_type, req_mon.has_instruction, req_mon.mode,
                    req_mon.first_reg_value, req_mon.first_reg_is_c,
                    req_mon.second_reg_value, req_mon.second_reg_is_c,
                    req_mon.pc_in, req_mon.hl_in, req_mon.bus_data};
            pending_results.push_back(fetch_result(beat));
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== sim/tb_sm83_operand_fetch.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_sm83_operand_fetch
// Drives the operand fetch stage with a short directed pass over every
// addressing mode and the corner cases, then with random fetch sequences
// (mostly well formed, some stray or truncated bus data) under four mixes of
// sender idling and receiver stalls. Checking is done by the fetch checker.
// ============================================================================
module tb_sm83_operand_fetch;
   import sm83of_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BEATS  = 406;
   localparam int SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   beats_sent = 0;
   int   send_idle_pct = 0;
   int   take_stall_pct = 0;
   int   send_idle_set[4]  = '{0, 82, 0, 15};
   int   take_stall_set[4] = '{0, 0, 82, 15};

   int fail_count;
   int outstanding;
   int rsp_count;
   int read_count;
   int done_count;
   int fault_count;

   sm83of_req_if req_ch ();
   sm83of_rsp_if rsp_ch ();

   sm83_operand_fetch dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sm83of_fetch_checker fetch_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .rsp_count   (rsp_count),
      .read_count  (read_count),
      .done_count  (done_count),
      .fault_count (fault_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.req_type, req_ch.has_instruction, req_ch.mode, req_ch.first_reg_value,
       req_ch.first_reg_is_c, req_ch.second_reg_value, req_ch.second_reg_is_c,
       req_ch.pc_in, req_ch.hl_in, req_ch.bus_data} = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock)
      rsp_ch.ready <= (take_stall_pct == 0) || ($urandom_range(99) >= take_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still pending",
                  cycle_count, outstanding);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'hFF, 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type b;
      b.req_type = 1'($urandom);
      b.has_instruction = 1'($urandom);
      b.mode = 5'($urandom);
      b.first_reg_value = pick16();
      b.first_reg_is_c = 1'($urandom);
      b.second_reg_value = pick16();
      b.second_reg_is_c = 1'($urandom);
      b.pc_in = pick16();
      b.hl_in = pick16();
      b.bus_data = 8'($urandom);
      return b;
   endfunction

   function automatic int reads_for_mode(logic [4:0] m);
      case (mode_type'(m))
         MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8, MODE_A8_R, MODE_MR_D8,
         MODE_R_MR, MODE_R_HLI, MODE_R_HLD, MODE_MR: return 1;
         MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R: return 2;
         MODE_R_A16: return 3;
         default: return 0;
      endcase
   endfunction

   task automatic send_beat(req_payload_type b);
      logic hit;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.req_type, req_ch.has_instruction, req_ch.mode, req_ch.first_reg_value,
       req_ch.first_reg_is_c, req_ch.second_reg_value, req_ch.second_reg_is_c,
       req_ch.pc_in, req_ch.hl_in, req_ch.bus_data} <= b;
      do begin
         @(negedge clock);
         hit = req_ch.ready;
         @(posedge clock);
      end while (!hit);
      beats_sent++;
   endtask

   task automatic send_data(logic [7:0] d);
      req_payload_type b;
      b = random_beat();
      b.req_type = REQ_DATA;
      b.bus_data = d;
      send_beat(b);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // every mode once, alternating all-zero and all-one operands, so pc and hl wrap
   task automatic run_directed();
      req_payload_type b;
      logic            ext;
      for (int m = 0; m <= 20; m++) begin
         ext = m[0];
         b.req_type = REQ_START;
         b.has_instruction = 1'b1;
         b.mode = 5'(m);
         b.first_reg_value = {16{ext}};
         b.first_reg_is_c = ext;
         b.second_reg_value = {16{ext}};
         b.second_reg_is_c = ext;
         b.pc_in = {16{ext}};
         b.hl_in = {16{ext}};
         b.bus_data = {8{~ext}};
         send_beat(b);
         for (int k = 0; k < reads_for_mode(b.mode); k++)
            send_data(k[0] ? {8{~ext}} : {8{ext}});
      end
      // no instruction, unknown modes, stray data, start while a fetch is open
      b = random_beat();
      b.req_type = REQ_START;
      b.has_instruction = 1'b0;
      send_beat(b);
      b.has_instruction = 1'b1;
      b.mode = 5'd31;
      send_beat(b);
      b.mode = 5'd21;
      send_beat(b);
      send_data(8'hA5);
      b.mode = MODE_R_A16;
      send_beat(b);
      send_data(8'h34);
      b.mode = MODE_R_D16;
      send_beat(b);
      send_data(8'h12);
      send_data(8'hEF);
   endtask

   task automatic send_random_fetch();
      req_payload_type b;
      int              choice;
      int              reads;
      choice = $urandom_range(99);
      b = random_beat();
      if (choice < 6) begin
         b.req_type = REQ_DATA;
         send_beat(b);
      end else begin
         b.req_type = REQ_START;
         b.has_instruction = (choice >= 10);
         b.mode = (choice < 14) ? 5'($urandom_range(31, 21)) : 5'($urandom_range(20));
         reads = b.has_instruction ? reads_for_mode(b.mode) : 0;
         if (choice >= 92)
            reads = (reads > 0 && choice[0]) ? $urandom_range(reads - 1) : reads + 1;
         send_beat(b);
         repeat (reads) send_data(8'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_idle_set[p];
         take_stall_pct = take_stall_set[p];
         while (beats_sent < 30 + (p + 1) * PHASE_BEATS)
            send_random_fetch();
         drain();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d request beats over all addressing modes, unknown modes, stray and",
               beats_sent);
      $display("  cut-short bus data; %0d responses (%0d reads, %0d done, %0d errors) checked",
               rsp_count, read_count, done_count, fault_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
